[hw/rtl/gregorian_date_calculator_macros.svh]
// Assertion macros for the date calculator RTL.
// GDC_ASSERT is held off while reset is active; GDC_ASSERT_ALWAYS is checked on every edge.
`ifndef GREGORIAN_DATE_CALCULATOR_MACROS_SVH
`define GREGORIAN_DATE_CALCULATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define GDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDC_ASSERT(label, clk, rst_n, prop, msg)
`define GDC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[hw/rtl/gdc_pkg.sv]
package gdc_pkg;

    // field widths
    localparam int W_DAY    = 5;
    localparam int W_MONTH  = 4;
    localparam int W_YEAR   = 14;
    localparam int W_SERIAL = 22;
    localparam int W_MLEN   = 5;
    localparam int W_WEEK   = 6;
    localparam int W_UNTIL  = 9;
    localparam int W_DOY    = 9;
    localparam int W_QUART  = 12;   // year / 4
    localparam int W_CENT   = 7;    // year / 100
    localparam int W_QCENT  = 5;    // year / 400
    localparam int W_PROD   = 24;   // (year / 4) * reciprocal of 25
    localparam int W_WKPROD = 17;   // (day of year - 1) * reciprocal of 7

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 88;

    // calendar constants
    localparam logic [W_YEAR-1:0]  YEAR_MAX      = 14'd9999;
    localparam logic [W_MONTH-1:0] MONTH_JAN     = 4'd1;
    localparam logic [W_MONTH-1:0] MONTH_FEB     = 4'd2;
    localparam logic [W_MONTH-1:0] MONTH_APR     = 4'd4;
    localparam logic [W_MONTH-1:0] MONTH_JUN     = 4'd6;
    localparam logic [W_MONTH-1:0] MONTH_SEP     = 4'd9;
    localparam logic [W_MONTH-1:0] MONTH_NOV     = 4'd11;
    localparam logic [W_MONTH-1:0] MONTH_DEC     = 4'd12;
    localparam logic [W_MLEN-1:0]  LEN_SHORT     = 5'd30;
    localparam logic [W_MLEN-1:0]  LEN_LONG      = 5'd31;
    localparam logic [W_MLEN-1:0]  LEN_FEB_LEAP  = 5'd29;
    localparam logic [W_MLEN-1:0]  LEN_FEB       = 5'd28;
    localparam int                 DAYS_PER_YEAR = 365;
    localparam int                 WEEK_MAX      = 53;
    localparam int                 UNTIL_MAX     = 366;

    // x / 25 == (x * 5243) >> 17 for x <= 2500
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;
    // x / 7 == (x * 293) >> 11 for x <= 365
    localparam logic [8:0]  DIV7_MUL    = 9'd293;
    localparam int          DIV7_SHIFT  = 11;

    // input fields, unpacked from the slave tdata
    typedef struct packed {
        logic [W_YEAR-1:0]  second_year;
        logic [W_MONTH-1:0] second_month;
        logic [W_DAY-1:0]   second_day;
        logic [W_YEAR-1:0]  first_year;
        logic [W_MONTH-1:0] first_month;
        logic [W_DAY-1:0]   first_day;
    } t_in;

    // stage 1: clamped dates and century products
    typedef struct packed {
        logic [W_DAY-1:0]   day_a;
        logic [W_MONTH-1:0] month_a;
        logic [W_YEAR-1:0]  year_a;
        logic [W_DAY-1:0]   day_b;
        logic [W_MONTH-1:0] month_b;
        logic [W_YEAR-1:0]  year_b;
        logic [W_YEAR-1:0]  year_n;
        logic [W_PROD-1:0]  prod_a;
        logic [W_PROD-1:0]  prod_b;
        logic [W_PROD-1:0]  prod_n;
    } t_s1;

    // year decode: leap flag and quotients of (year - 1)
    typedef struct packed {
        logic               leap;
        logic [W_YEAR-1:0]  p;
        logic [W_QUART-1:0] p4;
        logic [W_CENT-1:0]  p100;
        logic [W_QCENT-1:0] p400;
    } t_ydec;

    // stage 2: normalized dates and year decodes
    typedef struct packed {
        logic [W_DAY-1:0]   day_a;
        logic [W_MONTH-1:0] month_a;
        logic [W_YEAR-1:0]  year_a;
        logic [W_DAY-1:0]   day_b;
        logic [W_MONTH-1:0] month_b;
        t_ydec              dec_a;
        t_ydec              dec_b;
        logic               leap_n;
    } t_s2;

    // stage 3: days before year and day of year terms
    typedef struct packed {
        logic [W_DAY-1:0]    day_a;
        logic [W_MONTH-1:0]  month_a;
        logic [W_YEAR-1:0]   year_a;
        logic                leap_a;
        logic [W_MLEN-1:0]   mlen;
        logic [W_SERIAL-1:0] dby_a;
        logic [W_SERIAL-1:0] dby_b;
        logic [W_DOY-1:0]    doy_a;
        logic [W_DOY-1:0]    doy_b;
        logic [W_DOY-1:0]    doy_ann;
        logic [W_DOY-1:0]    doy_nx;
    } t_s3;

    // stage 4: serials, week product, anniversary count
    typedef struct packed {
        logic [W_DAY-1:0]    day_a;
        logic [W_MONTH-1:0]  month_a;
        logic [W_YEAR-1:0]   year_a;
        logic                leap_a;
        logic [W_MLEN-1:0]   mlen;
        logic [W_SERIAL-1:0] sa;
        logic [W_SERIAL-1:0] sb;
        logic [W_WKPROD-1:0] wk_prod;
        logic [W_UNTIL-1:0]  days_left;
    } t_s4;

    // result fields
    typedef struct packed {
        logic [W_UNTIL-1:0]  days_to_anniversary;
        logic [W_SERIAL-1:0] distance_days;
        logic [W_WEEK-1:0]   week_of_year;
        logic [W_MLEN-1:0]   month_length;
        logic                leap_flag;
        logic [W_SERIAL-1:0] serial_day;
        logic [W_YEAR-1:0]   norm_year;
        logic [W_MONTH-1:0]  norm_month;
        logic [W_DAY-1:0]    norm_day;
    } t_out;

    function automatic logic [W_MLEN-1:0] month_len(input logic [W_MONTH-1:0] m,
                                                    input logic leap);
        logic [W_MLEN-1:0] len;
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

    // days in the months before month m
    function automatic logic [W_DOY-1:0] cum_days(input logic [W_MONTH-1:0] m);
        logic [W_DOY-1:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [W_DOY-1:0] day_of_year(input logic [W_MONTH-1:0] m,
                                                     input logic [W_DAY-1:0] d,
                                                     input logic leap);
        logic extra;
        extra = (m > MONTH_FEB) && leap;
        return cum_days(m) + W_DOY'(d) + W_DOY'(extra);
    endfunction

endpackage

[hw/rtl/gdc_prep.sv]
// Stage 1: clamp the raw fields and form the year / 100 products
module gdc_prep import gdc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s1  o_data
);

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    function automatic logic [W_YEAR-1:0] clamp_year(input logic [W_YEAR-1:0] y);
        logic [W_YEAR-1:0] c;
        if (y == '0) begin
            c = W_YEAR'(1);
        end else if (y > YEAR_MAX) begin
            c = YEAR_MAX;
        end else begin
            c = y;
        end
        return c;
    endfunction

    function automatic logic [W_MONTH-1:0] clamp_month(input logic [W_MONTH-1:0] m);
        logic [W_MONTH-1:0] c;
        if (m == '0) begin
            c = MONTH_JAN;
        end else if (m > MONTH_DEC) begin
            c = MONTH_DEC;
        end else begin
            c = m;
        end
        return c;
    endfunction

    function automatic logic [W_DAY-1:0] clamp_day(input logic [W_DAY-1:0] d);
        return (d == '0) ? W_DAY'(1) : d;
    endfunction

    // (year / 4) times the reciprocal of 25
    function automatic logic [W_PROD-1:0] cent_prod(input logic [W_YEAR-1:0] y);
        return W_PROD'(y[W_YEAR-1:2]) * W_PROD'(DIV25_MUL);
    endfunction

    // clamping and products
    always_comb begin
        n_data.day_a   = clamp_day(i_data.first_day);
        n_data.month_a = clamp_month(i_data.first_month);
        n_data.year_a  = clamp_year(i_data.first_year);
        n_data.day_b   = clamp_day(i_data.second_day);
        n_data.month_b = clamp_month(i_data.second_month);
        n_data.year_b  = clamp_year(i_data.second_year);
        n_data.year_n  = n_data.year_a + W_YEAR'(1);
        n_data.prod_a  = cent_prod(n_data.year_a);
        n_data.prod_b  = cent_prod(n_data.year_b);
        n_data.prod_n  = cent_prod(n_data.year_n);
    end

    // stage register
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/gdc_norm.sv]
// Stage 2: leap decode and month carry of both dates
module gdc_norm import gdc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s1  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s2  o_data
);

    logic r_valid;
    t_s2  r_data;
    t_s2  n_data;
    t_ydec w_dec_n;

    // leap flag and quotients of (y - 1) from y / 100
    function automatic t_ydec year_dec(input logic [W_YEAR-1:0] y,
                                       input logic [W_PROD-1:0] prod);
        t_ydec             r;
        logic [W_CENT-1:0] q;
        logic [W_YEAR-1:0] hundreds;
        logic              z4;
        logic              z100;
        logic              z400;
        q        = prod[W_PROD-1:DIV25_SHIFT];
        hundreds = W_YEAR'({q, 6'b0}) + W_YEAR'({q, 5'b0}) + W_YEAR'({q, 2'b0});
        z4       = (y[1:0] == 2'b00);
        z100     = (y == hundreds);
        z400     = z100 && (q[1:0] == 2'b00);
        r.leap   = (z4 && !z100) || z400;
        r.p      = y - W_YEAR'(1);
        r.p4     = y[W_YEAR-1:2] - W_QUART'(z4);
        r.p100   = q - W_CENT'(z100);
        r.p400   = q[W_CENT-1:2] - W_QCENT'(z400);
        return r;
    endfunction

    // decode and carry; a day of at most 31 never leaves December
    always_comb begin
        logic [W_MLEN-1:0] len_a;
        logic [W_MLEN-1:0] len_b;
        n_data.dec_a  = year_dec(i_data.year_a, i_data.prod_a);
        n_data.dec_b  = year_dec(i_data.year_b, i_data.prod_b);
        w_dec_n       = year_dec(i_data.year_n, i_data.prod_n);
        n_data.leap_n = w_dec_n.leap;
        n_data.year_a = i_data.year_a;

        len_a = month_len(i_data.month_a, n_data.dec_a.leap);
        if (W_MLEN'(i_data.day_a) > len_a) begin
            n_data.day_a   = i_data.day_a - W_DAY'(len_a);
            n_data.month_a = i_data.month_a + W_MONTH'(1);
        end else begin
            n_data.day_a   = i_data.day_a;
            n_data.month_a = i_data.month_a;
        end

        len_b = month_len(i_data.month_b, n_data.dec_b.leap);
        if (W_MLEN'(i_data.day_b) > len_b) begin
            n_data.day_b   = i_data.day_b - W_DAY'(len_b);
            n_data.month_b = i_data.month_b + W_MONTH'(1);
        end else begin
            n_data.day_b   = i_data.day_b;
            n_data.month_b = i_data.month_b;
        end
    end

    // stage register
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/gdc_days.sv]
// Stage 3: days before each year and day-of-year terms
module gdc_days import gdc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s2  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s3  o_data
);

    logic r_valid;
    t_s3  r_data;
    t_s3  n_data;

    // 365 * p + p / 4 - p / 100 + p / 400
    function automatic logic [W_SERIAL-1:0] days_before(input t_ydec dec);
        return W_SERIAL'(dec.p) * W_SERIAL'(DAYS_PER_YEAR) + W_SERIAL'(dec.p4)
               - W_SERIAL'(dec.p100) + W_SERIAL'(dec.p400);
    endfunction

    // anniversary day of year, with a leap day moved to 1 March in a common year
    function automatic logic [W_DOY-1:0] ann_doy(input logic [W_MONTH-1:0] m,
                                                 input logic [W_DAY-1:0] d,
                                                 input logic leap);
        logic [W_MLEN-1:0]  len;
        logic [W_MONTH-1:0] mm;
        logic [W_DAY-1:0]   dd;
        len = month_len(m, leap);
        if (W_MLEN'(d) > len) begin
            dd = d - W_DAY'(len);
            mm = m + W_MONTH'(1);
        end else begin
            dd = d;
            mm = m;
        end
        return day_of_year(mm, dd, leap);
    endfunction

    always_comb begin
        n_data.day_a   = i_data.day_a;
        n_data.month_a = i_data.month_a;
        n_data.year_a  = i_data.year_a;
        n_data.leap_a  = i_data.dec_a.leap;
        n_data.mlen    = month_len(i_data.month_a, i_data.dec_a.leap);
        n_data.dby_a   = days_before(i_data.dec_a);
        n_data.dby_b   = days_before(i_data.dec_b);
        n_data.doy_a   = day_of_year(i_data.month_a, i_data.day_a, i_data.dec_a.leap);
        n_data.doy_b   = day_of_year(i_data.month_b, i_data.day_b, i_data.dec_b.leap);
        n_data.doy_ann = ann_doy(i_data.month_b, i_data.day_b, i_data.dec_a.leap);
        n_data.doy_nx  = ann_doy(i_data.month_b, i_data.day_b, i_data.leap_n);
    end

    // stage register
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/gdc_serial.sv]
// Stages 4 and 5: serial sums, anniversary count, distance, week, output register
module gdc_serial import gdc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s3  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic r_v4;
    t_s4  r_s4;
    t_s4  n_s4;
    logic w_rdy5;
    logic r_v5;
    t_out r_out;
    t_out n_out;

    // stage 4 logic; date a and the anniversary in the primary year share that year, so day of year decides
    always_comb begin
        logic [W_UNTIL:0] wrap;
        n_s4.day_a   = i_data.day_a;
        n_s4.month_a = i_data.month_a;
        n_s4.year_a  = i_data.year_a;
        n_s4.leap_a  = i_data.leap_a;
        n_s4.mlen    = i_data.mlen;
        n_s4.sa      = i_data.dby_a + W_SERIAL'(i_data.doy_a);
        n_s4.sb      = i_data.dby_b + W_SERIAL'(i_data.doy_b);
        n_s4.wk_prod = W_WKPROD'(i_data.doy_a - W_DOY'(1)) * W_WKPROD'(DIV7_MUL);
        wrap = (W_UNTIL+1)'(DAYS_PER_YEAR) + (W_UNTIL+1)'(i_data.leap_a)
               + (W_UNTIL+1)'(i_data.doy_nx) - (W_UNTIL+1)'(i_data.doy_a);
        if (i_data.doy_a < i_data.doy_ann) begin
            n_s4.days_left = W_UNTIL'(i_data.doy_ann - i_data.doy_a);
        end else if (i_data.doy_a > i_data.doy_ann) begin
            n_s4.days_left = wrap[W_UNTIL-1:0];
        end else begin
            n_s4.days_left = '0;
        end
    end

    // stage 5 logic
    always_comb begin
        n_out.norm_day            = r_s4.day_a;
        n_out.norm_month          = r_s4.month_a;
        n_out.norm_year           = r_s4.year_a;
        n_out.serial_day          = r_s4.sa;
        n_out.leap_flag           = r_s4.leap_a;
        n_out.month_length        = r_s4.mlen;
        n_out.week_of_year        = r_s4.wk_prod[W_WKPROD-1:DIV7_SHIFT] + W_WEEK'(1);
        n_out.distance_days       = (r_s4.sa > r_s4.sb) ? (r_s4.sa - r_s4.sb)
                                                        : (r_s4.sb - r_s4.sa);
        n_out.days_to_anniversary = r_s4.days_left;
    end

    // handshake chain
    assign w_rdy5  = !r_v5 || i_ready;
    assign o_ready = !r_v4 || w_rdy5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v4 <= i_valid;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s4 <= n_s4;
        end
        if (w_rdy5 && r_v4) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v5;
    assign o_data  = r_out;

endmodule

[hw/rtl/gregorian_date_calculator.sv]
// An accepted input transaction passes the prep, norm, days, stage 4 and output registers in turn.
// Throughput: one transaction per cycle unless backpressure stalls; five register stages, each with a valid bit.
// Backpressure stalls only the stages that are full; a free stage keeps taking data.
// Reset: i_rst_n synchronous, active low; clears all valid bits, data registers unreset.
`include "gregorian_date_calculator_macros.svh"

module gregorian_date_calculator import gdc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // fields from bit 0: first_day, first_month, first_year,
    // second_day, second_month, second_year, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // fields from bit 0: norm_day, norm_month, norm_year, serial_day, leap_flag,
    // month_length, week_of_year, distance_days, days_to_anniversary
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready
);

    t_in  w_in;
    t_s1  w_d1;
    t_s2  w_d2;
    t_s3  w_d3;
    t_out w_out;
    logic w_v1;
    logic w_v2;
    logic w_v3;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;

    // unpack input transaction
    assign w_in.first_day    = s_axis_tdata[4:0];
    assign w_in.first_month  = s_axis_tdata[8:5];
    assign w_in.first_year   = s_axis_tdata[22:9];
    assign w_in.second_day   = s_axis_tdata[27:23];
    assign w_in.second_month = s_axis_tdata[31:28];
    assign w_in.second_year  = s_axis_tdata[45:32];

    gdc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_in),
        .o_valid (w_v1),
        .i_ready (w_rdy2),
        .o_data  (w_d1)
    );

    gdc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_rdy2),
        .i_data  (w_d1),
        .o_valid (w_v2),
        .i_ready (w_rdy3),
        .o_data  (w_d2)
    );

    gdc_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_rdy3),
        .i_data  (w_d2),
        .o_valid (w_v3),
        .i_ready (w_rdy4),
        .o_data  (w_d3)
    );

    gdc_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_ready (w_rdy4),
        .i_data  (w_d3),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    // pack result transaction
    assign m_axis_tdata = {w_out.days_to_anniversary, w_out.distance_days,
                           w_out.week_of_year, w_out.month_length, w_out.leap_flag,
                           w_out.serial_day, w_out.norm_year, w_out.norm_month,
                           w_out.norm_day};

    // checks
    `GDC_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
    `GDC_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> w_v1, "accepted transaction not in stage 1")
    `GDC_ASSERT(a_feb_len, i_clk, i_rst_n, (m_axis_tvalid && (w_out.norm_month == MONTH_FEB)) |-> (w_out.month_length == (w_out.leap_flag ? LEN_FEB_LEAP : LEN_FEB)), "February length disagrees with leap flag")
    `GDC_ASSERT(a_ranges, i_clk, i_rst_n, m_axis_tvalid |-> ((w_out.week_of_year >= W_WEEK'(1)) && (w_out.week_of_year <= W_WEEK'(WEEK_MAX)) && (w_out.days_to_anniversary <= W_UNTIL'(UNTIL_MAX))), "week or anniversary count out of range")

endmodule
